/* sv/sws_pkg.sv */
// Shared types and codes for the stack with search and delete.
`timescale 1ns / 1ps
package sws_pkg;

	localparam int ValueW = 32;
	localparam int FillW  = 5;

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_SEARCH = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_TOP,
		IDX_DEC,
		IDX_INC
	} idx_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SHIFT,
		S_REPORT
	} state_t;

	typedef struct packed {
		logic    latch_in;
		idx_op_t idx_op;
		logic    rd_up;
		logic    wr_push;
		logic    wr_shift;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    set_status;
		status_t status;
		logic    load_out;
	} ctl_cmd_t;

	typedef struct packed {
		req_t req;
		logic empty;
		logic full;
		logic match;
		logic top_hit;
		logic idx_zero;
		logic shift_last;
		logic out_free;
	} dp_stat_t;

endpackage

/* sv/stack_with_search_and_delete.sv */
// Bounded LIFO of signed 32-bit values with search and delete by value.
// Usage:
//  Request channel (req_valid/req_stall, cmd, value): push, delete the
//  topmost entry equal to value, or search for value. cmd code 3 leaves the stack unchanged and is answered not found.
//  Response channel (rsp_valid/rsp_stall, status, fill_count): one response
//  per request, in order: ok/found, not found, empty or full, and the fill
//  count after the request.
//  One request is in work at a time; req_stall is low only while idle.
//  Steps from acceptance to rsp_valid rising, receiver not stalling:
//    push, or any request that needs no scan: decode, then report
//    search: decode, scan n entries from the top (n <= fill count), report
//    delete: as search, but m entries above the match move down before report
//  The next request is taken only after the response is loaded; the slowest,
//  deleting the bottom entry of a full stack, is set by the single read port
//  of the entry RAM: the scan and the close-up each move one entry per cycle.
//  A finished response waits in an output register while the next request is
//  taken; the following response is held back until that register is free.
//  Reset empties the stack and drops any pending response; RAM contents are
//  not cleared, as only entries below the fill count are ever read.
`timescale 1ns / 1ps
module stack_with_search_and_delete #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [1:0]                        cmd,
	input  logic signed [sws_pkg::ValueW-1:0] value,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [1:0]                        status,
	output logic [sws_pkg::FillW-1:0]         fill_count
);
	import sws_pkg::*;

	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;

	sws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (dp_stat),
		.cmd      (ctl_cmd)
	);

	sws_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd),
		.value_in  (value),
		.cmd       (ctl_cmd),
		.stat      (dp_stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.fill_count(fill_count)
	);

endmodule

/* sv/sws_ram.sv */
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module sws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/sws_ctrl.sv */
// Controller state machine: sequences push, scan, close-up and report.
`timescale 1ns / 1ps
module sws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sws_pkg::dp_stat_t stat,
	output sws_pkg::ctl_cmd_t cmd
);
	import sws_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.idx_op = IDX_HOLD;
		cmd.status = ST_OK;
		req_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.set_status = 1'b1;
				state_d        = S_REPORT;
				case (stat.req)
					REQ_PUSH: begin
						if (stat.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.wr_push = 1'b1;
							cmd.cnt_inc = 1'b1;
							cmd.status  = ST_OK;
						end
					end
					REQ_DELETE: begin
						if (stat.empty) begin
							cmd.status = ST_EMPTY;
						end else begin
							cmd.set_status = 1'b0;
							cmd.idx_op     = IDX_TOP;
							state_d        = S_SCAN;
						end
					end
					REQ_SEARCH: begin
						if (stat.empty) begin
							cmd.status = ST_NOTFOUND;
						end else begin
							cmd.set_status = 1'b0;
							cmd.idx_op     = IDX_TOP;
							state_d        = S_SCAN;
						end
					end
					default: begin
						cmd.status = ST_NOTFOUND;
					end
				endcase
			end
			S_SCAN: begin
				if (stat.match) begin
					if (stat.req != REQ_DELETE) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_OK;
						state_d        = S_REPORT;
					end else if (stat.top_hit) begin
						// top entry removed: nothing above to close up
						cmd.cnt_dec    = 1'b1;
						cmd.set_status = 1'b1;
						cmd.status     = ST_OK;
						state_d        = S_REPORT;
					end else begin
						cmd.rd_up = 1'b1;
						state_d   = S_SHIFT;
					end
				end else if (stat.idx_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOTFOUND;
					state_d        = S_REPORT;
				end else begin
					cmd.idx_op = IDX_DEC;
				end
			end
			S_SHIFT: begin
				cmd.wr_shift = 1'b1;
				if (stat.shift_last) begin
					cmd.cnt_dec    = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = ST_OK;
					state_d        = S_REPORT;
				end else begin
					cmd.idx_op = IDX_INC;
					cmd.rd_up  = 1'b1;
				end
			end
			S_REPORT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* sv/sws_dpath.sv */
// Datapath: entry RAM, fill count, scan index, request and result registers.
`timescale 1ns / 1ps
module sws_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    cmd_in,
	input  logic signed [sws_pkg::ValueW-1:0] value_in,
	input  sws_pkg::ctl_cmd_t             cmd,
	output sws_pkg::dp_stat_t             stat,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [1:0]                    status,
	output logic [sws_pkg::FillW-1:0]     fill_count
);
	import sws_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [1:0]        cmd_q;
	logic [ValueW-1:0] value_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q, idx_d;
	status_t           status_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [FillW-1:0]  out_fill_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [ValueW-1:0] ram_wdata, ram_rdata;

	always_comb begin
		case (cmd.idx_op)
			IDX_TOP:  idx_d = AW'(count_q - CW'(1));
			IDX_DEC:  idx_d = idx_q - AW'(1);
			IDX_INC:  idx_d = idx_q + AW'(1);
			default:  idx_d = idx_q;
		endcase
	end

	// read one above the index while closing up the gap
	assign ram_raddr = cmd.rd_up ? (idx_d + AW'(1)) : idx_d;
	assign ram_we    = cmd.wr_push | cmd.wr_shift;
	assign ram_waddr = cmd.wr_shift ? idx_q : count_q[AW-1:0];
	assign ram_wdata = cmd.wr_shift ? ram_rdata : value_q;

	sws_ram #(
		.WIDTH(ValueW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		stat.req        = req_t'(cmd_q);
		stat.empty      = (count_q == '0);
		stat.full       = (count_q == CW'(DEPTH));
		stat.match      = (ram_rdata == value_q);
		stat.top_hit    = ((CW'(idx_q) + CW'(1)) == count_q);
		stat.idx_zero   = (idx_q == '0);
		stat.shift_last = (((CW+1)'(idx_q) + (CW+1)'(2)) >= (CW+1)'(count_q));
		stat.out_free   = !out_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q   <= cmd_in;
			value_q <= value_in;
		end
		idx_q <= idx_d;
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_fill_q   <= FillW'(count_q);
		end
	end

	assign rsp_valid  = out_valid_q;
	assign status     = out_status_q;
	assign fill_count = out_fill_q;

endmodule
